// ===== rtl/keyword_substitution_cipher_macros.svh =====
// Assertion macros used by the checker file of the cipher block.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kcs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kcs assertion failed");

`endif

// ===== rtl/kcs_pkg.sv =====
`timescale 1ns / 1ps

package kcs_pkg;

  localparam int AlphabetSize = 26;
  localparam int LetterBits   = $clog2(AlphabetSize);

  localparam logic [LetterBits-1:0] LastLetter = LetterBits'(AlphabetSize - 1);

  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperZ = 8'h5a;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiLowerZ = 8'h7a;

  localparam logic CmdKey  = 1'b0;
  localparam logic CmdText = 1'b1;

  typedef logic [LetterBits-1:0] letter_t;

  typedef enum logic {
    StRun,
    StBuild
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic build_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_stall;
    logic build_last;
  } dp_status_t;

  function automatic letter_t wrap_next(letter_t n);
    letter_t r;
    r = (n == LastLetter) ? '0 : n + letter_t'(1);
    return r;
  endfunction

  function automatic logic is_upper(logic [7:0] b);
    return (b >= AsciiUpperA) && (b <= AsciiUpperZ);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return is_upper(b) || ((b >= AsciiLowerA) && (b <= AsciiLowerZ));
  endfunction

  function automatic letter_t letter_idx(logic [7:0] b);
    logic [7:0] d;
    d = is_upper(b) ? (b - AsciiUpperA) : (b - AsciiLowerA);
    return d[LetterBits-1:0];
  endfunction

endpackage

// ===== rtl/kcs_datapath.sv =====
`timescale 1ns / 1ps

module kcs_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kcs_pkg::dp_cmd_t    cmd_i,
  output kcs_pkg::dp_status_t status_o,
  input  logic                command_i,
  input  logic [7:0]          data_byte_i,
  input  logic                key_last_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o
);

  localparam int N = kcs_pkg::AlphabetSize;
  localparam logic [kcs_pkg::LetterBits-1:0] CountFull = kcs_pkg::LetterBits'(N);

  kcs_pkg::letter_t key_letters_q [N];
  kcs_pkg::letter_t table_q [N];
  kcs_pkg::letter_t table_d [N];

  logic                    building_q, building_d;
  logic [kcs_pkg::LetterBits-1:0] key_count_q, key_count_d;
  logic [N-1:0]            used_mask_q, used_mask_d;
  kcs_pkg::letter_t        raw_len_q, raw_len_d;
  kcs_pkg::letter_t        j_q, j_d;
  kcs_pkg::letter_t        pos_q, pos_d;
  kcs_pkg::letter_t        last_q, last_d;
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              out_byte_q, out_byte_d;

  logic [kcs_pkg::LetterBits-1:0] base_count;
  logic [N-1:0]            base_mask;
  kcs_pkg::letter_t        base_raw;
  kcs_pkg::letter_t        li;
  logic                    letter;
  logic                    key_acc, text_acc, key_add;
  logic                    use_key, wr_en;
  kcs_pkg::letter_t        v;

  always_comb begin
    letter     = kcs_pkg::is_letter(data_byte_i);
    li         = kcs_pkg::letter_idx(data_byte_i);
    key_acc    = cmd_i.accept && (command_i == kcs_pkg::CmdKey);
    text_acc   = cmd_i.accept && (command_i == kcs_pkg::CmdText);
    base_count = building_q ? key_count_q : '0;
    base_mask  = building_q ? used_mask_q : '0;
    base_raw   = building_q ? raw_len_q : '0;
    key_add    = letter && !base_mask[li] && (base_count < CountFull);

    use_key = j_q < key_count_q;
    v       = use_key ? key_letters_q[j_q] : kcs_pkg::wrap_next(last_q);
    wr_en   = cmd_i.build_step && (use_key || !used_mask_q[v]);

    building_d  = building_q;
    key_count_d = key_count_q;
    used_mask_d = used_mask_q;
    raw_len_d   = raw_len_q;
    j_d         = j_q;
    pos_d       = pos_q;
    last_d      = last_q;
    table_d     = table_q;

    if (key_acc) begin
      building_d  = !key_last_i;
      raw_len_d   = kcs_pkg::wrap_next(base_raw);
      key_count_d = key_add ? base_count + 1'b1 : base_count;
      used_mask_d = base_mask;
      if (key_add) begin
        used_mask_d[li] = 1'b1;
      end
      if (key_last_i) begin
        j_d    = '0;
        last_d = kcs_pkg::LastLetter;
        pos_d  = (raw_len_d == '0) ? kcs_pkg::LastLetter : raw_len_d - 1'b1;
      end
    end

    if (cmd_i.build_step) begin
      last_d = v;
      if (wr_en) begin
        table_d[pos_q] = v;
        pos_d          = kcs_pkg::wrap_next(pos_q);
        j_d            = j_q + 1'b1;
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    if (text_acc) begin
      out_valid_d = 1'b1;
      out_byte_d  = letter ? 8'(kcs_pkg::AsciiUpperA + {3'b000, table_q[li]}) : data_byte_i;
    end

    status_o.out_stall  = out_valid_q && !out_ready_i;
    status_o.build_last = wr_en && (j_q == kcs_pkg::LastLetter);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      building_q  <= 1'b0;
      key_count_q <= '0;
      used_mask_q <= '0;
      raw_len_q   <= '0;
      j_q         <= '0;
      pos_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        table_q[i] <= kcs_pkg::LetterBits'(i);
      end
    end else begin
      building_q  <= building_d;
      key_count_q <= key_count_d;
      used_mask_q <= used_mask_d;
      raw_len_q   <= raw_len_d;
      j_q         <= j_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      table_q     <= table_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    if (key_acc && key_add) begin
      key_letters_q[base_count] <= li;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

// ===== rtl/kcs_ctrl.sv =====
`timescale 1ns / 1ps

module kcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                command_i,
  input  logic                key_last_i,
  output logic                in_ready_o,
  output kcs_pkg::dp_cmd_t    cmd_o,
  input  kcs_pkg::dp_status_t status_i
);

  kcs_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcs_pkg::StRun;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.accept     = 1'b0;
    cmd_o.build_step = 1'b0;
    case (state_q)
      kcs_pkg::StRun: begin
        in_ready_o   = !status_i.out_stall;
        cmd_o.accept = in_valid_i && in_ready_o;
        if (cmd_o.accept && (command_i == kcs_pkg::CmdKey) && key_last_i) begin
          state_d = kcs_pkg::StBuild;
        end
      end
      kcs_pkg::StBuild: begin
        cmd_o.build_step = 1'b1;
        if (status_i.build_last) begin
          state_d = kcs_pkg::StRun;
        end
      end
      default: begin
        state_d = kcs_pkg::StRun;
      end
    endcase
  end

endmodule

// ===== rtl/keyword_substitution_cipher.sv =====
`timescale 1ns / 1ps

// Keyword substitution cipher over A..Z. Key bytes (tuser low) are counted,
// letters are folded to upper case and repeats dropped; the byte with tlast
// high builds the cipher table, and text bytes (tuser high) come back one
// item each, letters enciphered to upper case and other bytes unchanged.
// Outside a table build one item is taken per cycle while the output is not
// stalled, with a registered output stage. The build sequencer writes one
// table entry per key letter and tests one fill candidate per cycle, and the
// input stalls after the last key byte until the table is complete.
module keyword_substitution_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] command
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] out_byte
);

  kcs_pkg::dp_cmd_t    cmd;
  kcs_pkg::dp_status_t status;

  kcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .command_i  (s_axis_tuser),
    .key_last_i (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  kcs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .command_i   (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .key_last_i  (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/kcs_checker.sv =====
`timescale 1ns / 1ps

`include "keyword_substitution_cipher_macros.svh"

module kcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tuser,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  `KCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

  `KCS_ASSERT_NEXT(a_build_stalls, in_acc && !s_axis_tuser && s_axis_tlast, !s_axis_tready)

  `KCS_ASSERT_NEXT(a_text_gives_item, in_acc && s_axis_tuser, m_axis_tvalid)

  `KCS_ASSERT_NEXT(a_upper_out,
                   in_acc && s_axis_tuser && s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h5a,
                   m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h5a)

  `KCS_ASSERT_SAME(a_in_blocked_on_stall, m_axis_tvalid && !out_acc, !s_axis_tready)

endmodule

bind keyword_substitution_cipher kcs_checker u_kcs_checker (.*);
